### hdl/rgbls_pkg.sv
// rgbls_pkg: types, codes and helpers shared by the RGB LED string buffer.
// No dependencies.
`default_nettype none

package rgbls_pkg;

   localparam int unsigned WORD_W  = 24;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned INDEX_W = 4;
   localparam int unsigned CSR_W   = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_SET_ONE   = 3'd0,
      MODE_CLEAR_ONE = 3'd1,
      MODE_SET_ALL   = 3'd2,
      MODE_CLEAR_ALL = 3'd3,
      MODE_SHIFT_R   = 3'd4,
      MODE_SHIFT_L   = 3'd5,
      MODE_UPDATE    = 3'd6
   } mode_type;

   localparam logic [CSR_W-1:0] CSR_FILL_RED   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FILL_GREEN = 2'd1;
   localparam logic [CSR_W-1:0] CSR_FILL_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD_FILL,
      CELL_CLEAR,
      CELL_FROM_PREV,
      CELL_FROM_NEXT,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      cell_op_type               bulk_op;
      cell_op_type               one_op;
      logic [INDEX_W-1:0]        one_index;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic strobe;
      logic last;
   } status_type;

   function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int b = 0; b < BYTE_W; b++) begin
         r[b] = v[BYTE_W-1-b];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/rgbls_cell.sv
// rgbls_cell: one pixel of the LED string, a 24-bit green/red/blue word.
// Depends on rgbls_pkg.
`default_nettype none

module rgbls_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rgbls_pkg::cell_op_type      op,
   input  wire logic [rgbls_pkg::WORD_W-1:0] fill_word,
   input  wire logic [rgbls_pkg::WORD_W-1:0] prev_word,
   input  wire logic [rgbls_pkg::WORD_W-1:0] next_word,
   input  wire logic [rgbls_pkg::BYTE_W-1:0] rot_byte,
   output logic      [rgbls_pkg::WORD_W-1:0] word
);

   logic [rgbls_pkg::WORD_W-1:0] word_ff;
   logic [rgbls_pkg::WORD_W-1:0] word_in;

   always_comb begin
      unique case (op)
         rgbls_pkg::CELL_HOLD:      word_in = word_ff;
         rgbls_pkg::CELL_LOAD_FILL: word_in = fill_word;
         rgbls_pkg::CELL_CLEAR:     word_in = '0;
         rgbls_pkg::CELL_FROM_PREV: word_in = prev_word;
         rgbls_pkg::CELL_FROM_NEXT: word_in = next_word;
         rgbls_pkg::CELL_ROTATE:
            word_in = {word_ff[rgbls_pkg::WORD_W-rgbls_pkg::BYTE_W-1:0], rot_byte};
         default:                   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule

`default_nettype wire

### hdl/rgbls_ctrl.sv
// rgbls_ctrl: command decode and update sequencer for the cell chain.
// Depends on rgbls_pkg.
`default_nettype none

module rgbls_ctrl #(
   parameter int unsigned LED_COUNT = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rgbls_pkg::MODE_W-1:0]  mode,
   input  wire logic [rgbls_pkg::INDEX_W-1:0] pixel_index,
   output rgbls_pkg::cmd_type                 cmd,
   output rgbls_pkg::status_type              status
);

   localparam int unsigned BYTES   = 3 * LED_COUNT;
   localparam int unsigned CNT_W   = $clog2(BYTES);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(BYTES - 1);

   rgbls_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rgbls_pkg::ST_IDLE: begin
            if (start && (mode == rgbls_pkg::MODE_UPDATE)) begin
               state_in = rgbls_pkg::ST_UPDATE;
            end
         end
         rgbls_pkg::ST_UPDATE: begin
            if (count_ff == LAST_COUNT) begin
               state_in = rgbls_pkg::ST_IDLE;
            end
         end
         default: state_in = rgbls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.bulk_op   = rgbls_pkg::CELL_HOLD;
      cmd.one_op    = rgbls_pkg::CELL_HOLD;
      cmd.one_index = pixel_index;
      status.busy   = 1'b0;
      status.strobe = 1'b0;
      status.last   = 1'b0;
      count_in      = '0;
      unique case (state_ff)
         rgbls_pkg::ST_IDLE: begin
            if (start) begin
               unique case (mode)
                  rgbls_pkg::MODE_SET_ONE:   cmd.one_op  = rgbls_pkg::CELL_LOAD_FILL;
                  rgbls_pkg::MODE_CLEAR_ONE: cmd.one_op  = rgbls_pkg::CELL_CLEAR;
                  rgbls_pkg::MODE_SET_ALL:   cmd.bulk_op = rgbls_pkg::CELL_LOAD_FILL;
                  rgbls_pkg::MODE_CLEAR_ALL: cmd.bulk_op = rgbls_pkg::CELL_CLEAR;
                  rgbls_pkg::MODE_SHIFT_R:   cmd.bulk_op = rgbls_pkg::CELL_FROM_PREV;
                  rgbls_pkg::MODE_SHIFT_L:   cmd.bulk_op = rgbls_pkg::CELL_FROM_NEXT;
                  default: ;
               endcase
            end
         end
         rgbls_pkg::ST_UPDATE: begin
            cmd.bulk_op   = rgbls_pkg::CELL_ROTATE;
            status.busy   = 1'b1;
            status.strobe = 1'b1;
            status.last   = (count_ff == LAST_COUNT);
            count_in      = count_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgbls_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rgb_led_string_buffer_core.sv
// rgb_led_string_buffer_core: top level of the RGB LED string frame buffer.
// Depends on rgbls_pkg, rgbls_cell and rgbls_ctrl.
// Every command except update completes in the cycle it is transferred; start is taken
// whenever busy is low. An update raises busy from the cycle after its transfer until
// its last byte has left, during which the chain of pixel cells rotates one byte per
// cycle toward pixel 0 and rsp_strobe marks one byte per cycle (green, red, blue, pixel 0
// first, bit-reversed), with rsp_last_byte on the final one. The receiver cannot stall
// the stream; each byte is on the ports for exactly one cycle. After the run the store
// is back in its original order. Reset clears all pixels and fill registers.
`default_nettype none

module rgb_led_string_buffer_core #(
   parameter int unsigned LED_COUNT = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rgbls_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [rgbls_pkg::INDEX_W-1:0] req_pixel_index,
   output logic                               rsp_strobe,
   output logic      [rgbls_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                               rsp_last_byte,
   input  wire logic                          csr_we,
   input  wire logic [rgbls_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [rgbls_pkg::BYTE_W-1:0]  csr_wdata
);

   localparam int unsigned CELL_IDX_W = rgbls_pkg::INDEX_W + 1;
   localparam int unsigned W = rgbls_pkg::WORD_W;
   localparam int unsigned B = rgbls_pkg::BYTE_W;

   logic [B-1:0] fill_red_ff, fill_green_ff, fill_blue_ff;
   logic [W-1:0] fill_word;
   logic [W-1:0] words [LED_COUNT];

   rgbls_pkg::cmd_type    cmd;
   rgbls_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_red_ff   <= '0;
         fill_green_ff <= '0;
         fill_blue_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rgbls_pkg::CSR_FILL_RED:   fill_red_ff   <= csr_wdata;
            rgbls_pkg::CSR_FILL_GREEN: fill_green_ff <= csr_wdata;
            rgbls_pkg::CSR_FILL_BLUE:  fill_blue_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fill_word = {fill_green_ff, fill_red_ff, fill_blue_ff};

   rgbls_ctrl #(
      .LED_COUNT(LED_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .mode       (req_mode),
      .pixel_index(req_pixel_index),
      .cmd        (cmd),
      .status     (status)
   );

   for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
      rgbls_pkg::cell_op_type op;
      logic [W-1:0]           prev_word;
      logic [W-1:0]           next_word;
      logic [B-1:0]           rot_byte;

      always_comb begin
         if (cmd.bulk_op != rgbls_pkg::CELL_HOLD) begin
            op = cmd.bulk_op;
         end else if ({1'b0, cmd.one_index} == CELL_IDX_W'(i)) begin
            op = cmd.one_op;
         end else begin
            op = rgbls_pkg::CELL_HOLD;
         end
      end

      if (i == 0) begin : g_first
         assign prev_word = fill_word;
      end else begin : g_mid_prev
         assign prev_word = words[i-1];
      end

      if (i == LED_COUNT - 1) begin : g_last
         assign next_word = fill_word;
         assign rot_byte  = words[0][W-1:W-B];
      end else begin : g_mid_next
         assign next_word = words[i+1];
         assign rot_byte  = words[i+1][W-1:W-B];
      end

      rgbls_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .fill_word(fill_word),
         .prev_word(prev_word),
         .next_word(next_word),
         .rot_byte (rot_byte),
         .word     (words[i])
      );
   end

   assign busy          = status.busy;
   assign rsp_strobe    = status.strobe;
   assign rsp_last_byte = status.last;
   assign rsp_out_byte  = rgbls_pkg::reverse8(words[0][W-1:W-B]);

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside an update run");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_byte) |=> !busy)
      else $error("busy held after last byte");

   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == rgbls_pkg::MODE_UPDATE)) |=> (busy && rsp_strobe))
      else $error("update transfer did not start a run");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> $stable(words[0]))
      else $error("pixel 0 changed with no command");
`endif

endmodule

`default_nettype wire
